// ===== sv/assert_macros.svh =====
// Assertion macros shared by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tpt assertion failed");

// Next-cycle implication, disabled during reset.
`define TPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tpt assertion failed");

`endif

// ===== sv/tpt_pkg.sv =====
// Shared constants and types of the TLB / page table translator.
package tpt_pkg;

    localparam int ADDR_W = 16;
    localparam int CNT_W  = 32;

    localparam int TLB_ENTRIES_DEF  = 16;
    localparam int OFFSET_WIDTH_DEF = 8;
    localparam int PAGE_WIDTH_DEF   = 8;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [ADDR_W-1:0] physical_address;
        logic              tlb_hit;
        logic              page_fault;
        t_cnt              hit_total;
        t_cnt              fault_total;
        t_cnt              access_total;
    } t_rsp;

    // Saturating increment of a running count.
    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ===== sv/tpt_if.sv =====
// Request and response channel interfaces of the translator.
interface tpt_req_if import tpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink   (input valid, input virtual_address, output ready);
endinterface

interface tpt_rsp_if import tpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] physical_address;
    logic              tlb_hit;
    logic              page_fault;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  fault_total;
    logic [CNT_W-1:0]  access_total;

    modport source (output valid, output physical_address, output tlb_hit,
                    output page_fault, output hit_total, output fault_total,
                    output access_total, input ready);
    modport sink   (input valid, input physical_address, input tlb_hit,
                    input page_fault, input hit_total, input fault_total,
                    input access_total, output ready);
endinterface

// ===== sv/tpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tpt_tlb_cell.sv =====
// One TLB cell: holds a page/frame pair, compares it, hands it on when the row shifts.
module tpt_tlb_cell #(
    parameter int PAGE_W  = 8,
    parameter int FRAME_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic               i_valid,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic [PAGE_W-1:0]  i_lookup_page,
    output logic               o_valid,
    output logic [PAGE_W-1:0]  o_page,
    output logic [FRAME_W-1:0] o_frame,
    output logic               o_hit,
    output logic [FRAME_W-1:0] o_hit_frame
);

    logic               r_valid;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_page  <= i_page;
            r_frame <= i_frame;
        end
    end

    assign o_valid     = r_valid;
    assign o_page      = r_page;
    assign o_frame     = r_frame;
    assign o_hit       = r_valid && (r_page == i_lookup_page);
    // masked so the row can OR all cells together
    assign o_hit_frame = o_hit ? r_frame : '0;

endmodule

// ===== sv/tlb_page_table_translator_top.sv =====
// Top level: FIFO TLB built as a shifting row of cells, backed by a demand-paged page table.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  i_req   | in  | valid/ready          | virtual_address[15:0]
//  o_rsp   | out | valid/ready          | physical_address, tlb_hit, page_fault,
//          |     |                      | hit_total, fault_total, access_total
//
//  A request is accepted in S_IDLE and compared against the TLB in S_LOOK; a miss
//  adds S_MISS for the registered read of the page-table RAM. One request is in
//  flight at a time. After reset the page table is cleared one entry per cycle,
//  all 2**PAGE_WIDTH entries (256 by default), with i_req.ready held low.
//  The result register lets a new request be accepted while o_rsp waits; a lookup
//  that finishes while o_rsp is still stalled holds until the slot frees.
`include "assert_macros.svh"

module tlb_page_table_translator_top import tpt_pkg::*; #(
    parameter int TLB_ENTRIES  = TLB_ENTRIES_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    parameter int PAGE_WIDTH   = PAGE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpt_req_if.sink   i_req,
    tpt_rsp_if.source o_rsp
);

    // frame numbers have the same width as page numbers
    localparam int FRAME_W = PAGE_WIDTH;
    localparam int PT_W    = FRAME_W + 1;          // {mapped, frame}
    localparam int PT_D    = 1 << PAGE_WIDTH;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_MISS  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [PAGE_WIDTH-1:0] r_clr_idx, n_clr_idx;
    logic [ADDR_W-1:0]     r_va;
    logic [FRAME_W-1:0]    r_next_free, n_next_free;
    t_cnt                  r_hit_cnt, n_hit_cnt;
    t_cnt                  r_fault_cnt, n_fault_cnt;
    t_cnt                  r_access_cnt, n_access_cnt;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_rsp, n_rsp;

    // Address split. Widening before the shift keeps the page bits that lie
    // above bit 15 at zero in wide configurations.
    logic [PAGE_WIDTH+ADDR_W-1:0]  w_va_ext;
    logic [PAGE_WIDTH-1:0]         w_page;
    logic [OFFSET_WIDTH-1:0]       w_offset;

    assign w_va_ext = {{PAGE_WIDTH{1'b0}}, r_va} >> OFFSET_WIDTH;
    assign w_page   = w_va_ext[PAGE_WIDTH-1:0];
    assign w_offset = r_va[OFFSET_WIDTH-1:0];

    // ---------------------------------------------------------------------
    // TLB row: cell 0 takes the newest pair, the oldest drops off the end.
    // ---------------------------------------------------------------------
    logic                  w_shift;
    logic [FRAME_W-1:0]    w_ins_frame;
    logic [TLB_ENTRIES:0]  w_chain_valid;
    logic [PAGE_WIDTH-1:0] w_chain_page  [TLB_ENTRIES+1];
    logic [FRAME_W-1:0]    w_chain_frame [TLB_ENTRIES+1];
    logic [TLB_ENTRIES-1:0] w_cell_hit;
    logic [FRAME_W-1:0]    w_cell_frame  [TLB_ENTRIES];

    assign w_chain_valid[0] = 1'b1;
    assign w_chain_page[0]  = w_page;
    assign w_chain_frame[0] = w_ins_frame;

    for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
        tpt_tlb_cell #(
            .PAGE_W  (PAGE_WIDTH),
            .FRAME_W (FRAME_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (w_shift),
            .i_valid       (w_chain_valid[g]),
            .i_page        (w_chain_page[g]),
            .i_frame       (w_chain_frame[g]),
            .i_lookup_page (w_page),
            .o_valid       (w_chain_valid[g+1]),
            .o_page        (w_chain_page[g+1]),
            .o_frame       (w_chain_frame[g+1]),
            .o_hit         (w_cell_hit[g]),
            .o_hit_frame   (w_cell_frame[g])
        );
    end

    // at most one cell matches, so an OR of the masked frames selects it
    logic               w_hit;
    logic [FRAME_W-1:0] w_tlb_frame;

    assign w_hit = |w_cell_hit;

    always_comb begin
        w_tlb_frame = '0;
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            w_tlb_frame = w_tlb_frame | w_cell_frame[k];
        end
    end

    // ---------------------------------------------------------------------
    // Page table RAM: {mapped, frame} per page, read at the current page.
    // ---------------------------------------------------------------------
    logic                  w_pt_we;
    logic [PAGE_WIDTH-1:0] w_pt_waddr;
    logic [PT_W-1:0]       w_pt_wdata;
    logic [PT_W-1:0]       w_pt_rdata;
    logic                  w_pt_mapped;

    assign w_pt_mapped = w_pt_rdata[FRAME_W];

    tpt_ram #(
        .WIDTH (PT_W),
        .DEPTH (PT_D)
    ) u_page_table (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (w_pt_waddr),
        .i_wdata (w_pt_wdata),
        .i_raddr (w_page),
        .o_rdata (w_pt_rdata)
    );

    // ---------------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------------
    logic                            w_out_free;
    logic                            w_accept;
    logic [FRAME_W-1:0]              w_frame;
    logic [FRAME_W+OFFSET_WIDTH+ADDR_W-1:0] w_pa_ext;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // frame used for a miss: table frame when mapped, else the next free one
    assign w_ins_frame = w_pt_mapped ? w_pt_rdata[FRAME_W-1:0] : r_next_free;
    assign w_frame     = (r_state == S_LOOK) ? w_tlb_frame : w_ins_frame;
    assign w_pa_ext    = {{ADDR_W{1'b0}}, w_frame, w_offset};

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_next_free  = r_next_free;
        n_hit_cnt    = r_hit_cnt;
        n_fault_cnt  = r_fault_cnt;
        n_access_cnt = r_access_cnt;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_rsp        = r_rsp;
        w_shift      = 1'b0;
        w_pt_we      = 1'b0;
        w_pt_waddr   = w_page;
        w_pt_wdata   = {1'b1, r_next_free};

        case (r_state)
            S_CLEAR: begin
                w_pt_we    = 1'b1;
                w_pt_waddr = r_clr_idx;
                w_pt_wdata = '0;
                n_clr_idx  = r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!w_hit) begin
                    n_state = S_MISS;
                end else if (w_out_free) begin
                    n_hit_cnt            = sat_inc(r_hit_cnt);
                    n_access_cnt         = sat_inc(r_access_cnt);
                    n_out_valid          = 1'b1;
                    n_rsp.physical_address = w_pa_ext[ADDR_W-1:0];
                    n_rsp.tlb_hit        = 1'b1;
                    n_rsp.page_fault     = 1'b0;
                    n_rsp.hit_total      = n_hit_cnt;
                    n_rsp.fault_total    = r_fault_cnt;
                    n_rsp.access_total   = n_access_cnt;
                    n_state              = S_IDLE;
                end
            end
            S_MISS: begin
                if (w_out_free) begin
                    w_shift = 1'b1;
                    if (!w_pt_mapped) begin
                        w_pt_we     = 1'b1;
                        n_next_free = r_next_free + 1'b1;
                        n_fault_cnt = sat_inc(r_fault_cnt);
                    end
                    n_access_cnt         = sat_inc(r_access_cnt);
                    n_out_valid          = 1'b1;
                    n_rsp.physical_address = w_pa_ext[ADDR_W-1:0];
                    n_rsp.tlb_hit        = 1'b0;
                    n_rsp.page_fault     = !w_pt_mapped;
                    n_rsp.hit_total      = r_hit_cnt;
                    n_rsp.fault_total    = n_fault_cnt;
                    n_rsp.access_total   = n_access_cnt;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_next_free  <= '0;
            r_hit_cnt    <= '0;
            r_fault_cnt  <= '0;
            r_access_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_next_free  <= n_next_free;
            r_hit_cnt    <= n_hit_cnt;
            r_fault_cnt  <= n_fault_cnt;
            r_access_cnt <= n_access_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (w_accept) begin
            r_va <= i_req.virtual_address;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.physical_address = r_rsp.physical_address;
    assign o_rsp.tlb_hit          = r_rsp.tlb_hit;
    assign o_rsp.page_fault       = r_rsp.page_fault;
    assign o_rsp.hit_total        = r_rsp.hit_total;
    assign o_rsp.fault_total      = r_rsp.fault_total;
    assign o_rsp.access_total     = r_rsp.access_total;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // a page is inserted only on a miss, so no two cells may match
    `TPT_ASSERT_IMPLY(a_single_match, i_clk, i_rst_n, r_state == S_LOOK, $onehot0(w_cell_hit))
    // a fault only ever comes from the miss path
    `TPT_ASSERT_IMPLY(a_fault_not_hit, i_clk, i_rst_n, o_rsp.valid, !(o_rsp.tlb_hit && o_rsp.page_fault))
    // every hit and every fault is also an access
    `TPT_ASSERT_IMPLY(a_totals_order, i_clk, i_rst_n, o_rsp.valid, (o_rsp.access_total >= o_rsp.hit_total) && (o_rsp.access_total >= o_rsp.fault_total))
    // an accepted request always goes to the TLB compare next
    `TPT_ASSERT_NEXT(a_accept_look, i_clk, i_rst_n, w_accept, r_state == S_LOOK)

endmodule

// ===== test/tlb_page_table_translator_top_tb.sv =====
// Self-checking testbench of the TLB / page table translator: directed and random requests.
module tlb_page_table_translator_top_tb import tpt_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          RANDOM_REQS = 850;
    localparam int          IDLE_PCT    = 32;

    // Opening sequence: address extremes, a hit on the same page, then enough new pages
    // to wrap the FIFO and evict page 0 and page FF, which then miss without faulting.
    localparam logic [ADDR_W-1:0] DIRECTED [23] = '{
        16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00,
        16'h01AA, 16'h0255, 16'h03AA, 16'h0455, 16'h05AA, 16'h0655, 16'h07AA,
        16'h0855, 16'h09AA, 16'h0A55, 16'h0BAA, 16'h0C55, 16'h0DAA, 16'h0E55,
        16'h0F01, 16'h0080, 16'hFF7F, 16'h0F0F, 16'h01FE
    };

    // Mirror of the translator: FIFO TLB, page table with frame allocation, counts.
    class translation_scoreboard;
        localparam int TLB_N = TLB_ENTRIES_DEF;
        localparam int PAGES = 1 << PAGE_WIDTH_DEF;

        logic [7:0] cached_page  [TLB_N];
        logic [7:0] cached_frame [TLB_N];
        bit         cached_valid [TLB_N];
        logic [3:0] fifo_slot;
        bit         mapped       [PAGES];
        logic [7:0] frame_of     [PAGES];
        logic [7:0] free_frame;
        t_cnt       hits;
        t_cnt       faults;
        t_cnt       accesses;
        t_rsp       pending_translations[$];
        int         checked;
        int         errors;

        function new();
            foreach (cached_valid[i]) cached_valid[i] = 1'b0;
            foreach (mapped[i]) mapped[i] = 1'b0;
            fifo_slot  = '0;
            free_frame = '0;
            hits       = '0;
            faults     = '0;
            accesses   = '0;
            checked    = 0;
            errors     = 0;
        endfunction

        function void translate_request(logic [ADDR_W-1:0] va);
            logic [7:0] page;
            logic [7:0] frame;
            bit         hit;
            bit         fault;
            t_rsp       want;
            page  = va[15:8];
            frame = '0;
            hit   = 1'b0;
            fault = 1'b0;
            // lowest matching slot wins
            for (int i = 0; i < TLB_N; i++) begin
                if (!hit && cached_valid[i] && cached_page[i] == page) begin
                    frame = cached_frame[i];
                    hit   = 1'b1;
                end
            end
            if (hit) begin
                hits = (hits == '1) ? hits : hits + 1'b1;
            end else begin
                if (mapped[page]) begin
                    frame = frame_of[page];
                end else begin
                    fault          = 1'b1;
                    faults         = (faults == '1) ? faults : faults + 1'b1;
                    frame          = free_frame;
                    free_frame     = free_frame + 1'b1;
                    frame_of[page] = frame;
                    mapped[page]   = 1'b1;
                end
                cached_page[fifo_slot]  = page;
                cached_frame[fifo_slot] = frame;
                cached_valid[fifo_slot] = 1'b1;
                fifo_slot               = fifo_slot + 1'b1;
            end
            accesses = (accesses == '1) ? accesses : accesses + 1'b1;

            want.physical_address = {frame, va[7:0]};
            want.tlb_hit          = hit;
            want.page_fault       = fault;
            want.hit_total        = hits;
            want.fault_total      = faults;
            want.access_total     = accesses;
            pending_translations.push_back(want);
        endfunction

        task report(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
            $display("response %0d: %s got %0h, expected %0h", checked, what, got, want);
            errors++;
        endtask

        task check_response(t_rsp got);
            t_rsp want;
            checked++;
            if (pending_translations.size() == 0) begin
                report("response with no request pending",
                       CNT_W'(got.physical_address), '0);
            end else begin
                want = pending_translations.pop_front();
                if (got.physical_address !== want.physical_address)
                    report("physical_address", CNT_W'(got.physical_address),
                           CNT_W'(want.physical_address));
                if (got.tlb_hit !== want.tlb_hit)
                    report("tlb_hit", CNT_W'(got.tlb_hit), CNT_W'(want.tlb_hit));
                if (got.page_fault !== want.page_fault)
                    report("page_fault", CNT_W'(got.page_fault), CNT_W'(want.page_fault));
                if (got.hit_total !== want.hit_total)
                    report("hit_total", got.hit_total, want.hit_total);
                if (got.fault_total !== want.fault_total)
                    report("fault_total", got.fault_total, want.fault_total);
                if (got.access_total !== want.access_total)
                    report("access_total", got.access_total, want.access_total);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    bit          steady;      // no idling on either side while set
    int unsigned cycles = 0;

    translation_scoreboard sb = new();

    tpt_req_if req_if ();
    tpt_rsp_if rsp_if ();

    tlb_page_table_translator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                     sb.pending_translations.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Response side: random stalls, sampled at the rising edge.
    always @(negedge i_clk)
        rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(t_rsp'{physical_address: rsp_if.physical_address,
                                     tlb_hit:          rsp_if.tlb_hit,
                                     page_fault:       rsp_if.page_fault,
                                     hit_total:        rsp_if.hit_total,
                                     fault_total:      rsp_if.fault_total,
                                     access_total:     rsp_if.access_total});
    end

    // Entered and left at a falling edge; valid stays high across back-to-back requests.
    task automatic send_request(input logic [ADDR_W-1:0] va);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid           = 1'b1;
        req_if.virtual_address = va;
        do @(posedge i_clk); while (!req_if.ready);
        sb.translate_request(va);
        @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] sweep [256];
        logic [7:0] hot   [12];
        logic [7:0] warm  [24];
        logic [7:0] page;
        logic [7:0] swap;
        int         sweep_idx;
        int         pick;
        int         j;

        steady                 = 1'b0;
        i_rst_n                = 1'b0;
        req_if.valid           = 1'b0;
        req_if.virtual_address = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // The block clears its page table first; send_request just waits on ready.
        foreach (DIRECTED[i]) send_request(DIRECTED[i]);

        // Every page gets touched once in shuffled order, so the whole frame pool is used.
        for (int i = 0; i < 256; i++) sweep[i] = 8'(i);
        for (int i = 255; i > 0; i--) begin
            j        = $urandom_range(i);
            swap     = sweep[i];
            sweep[i] = sweep[j];
            sweep[j] = swap;
        end
        // small hot set mostly hits; warm set is larger than the TLB and thrashes it
        foreach (hot[i]) hot[i] = 8'($urandom());
        foreach (warm[i]) warm[i] = 8'($urandom());
        sweep_idx = 0;

        for (int n = 0; n < RANDOM_REQS; n++) begin
            steady = (n >= 300 && n < 450);
            pick   = $urandom_range(99);
            if (pick < 30 && sweep_idx < 256) begin
                page = sweep[sweep_idx];
                sweep_idx++;
            end else if (pick < 60) begin
                page = hot[$urandom_range(11)];
            end else if (pick < 80) begin
                page = warm[$urandom_range(23)];
            end else begin
                page = 8'($urandom());
            end
            send_request({page, 8'($urandom())});
        end
        steady = 1'b0;
        for (; sweep_idx < 256; sweep_idx++) begin
            if (!sb.mapped[sweep[sweep_idx]])
                send_request({sweep[sweep_idx], 8'($urandom())});
        end
        req_if.valid = 1'b0;

        while (sb.pending_translations.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d requests translated: %0d TLB hits, %0d page faults,",
                 sb.accesses, sb.hits, sb.faults);
        $display("frame pool pointer at %0h after all 256 pages were mapped", sb.free_frame);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tpt_pkg.sv
sv/tpt_if.sv
sv/tpt_ram.sv
sv/tpt_tlb_cell.sv
sv/tlb_page_table_translator_top.sv
test/tlb_page_table_translator_top_tb.sv
